[hdl/tlpd_pkg.sv]
// shared types and constants for the typed length packet deframer
package tlpd_pkg;

    // header type bytes used in typed framing
    localparam logic [7:0] TYPE_C1 = 8'hC1;
    localparam logic [7:0] TYPE_C2 = 8'hC2;

    // header lengths in bytes
    localparam logic [15:0] HDR_LEN_SHORT = 16'd3;
    localparam logic [15:0] HDR_LEN_LONG  = 16'd4;

    // framing mode register values
    localparam logic MODE_TYPED = 1'b0;
    localparam logic MODE_PLAIN = 1'b1;

    typedef enum logic {
        PH_HUNT   = 1'b0,
        PH_IN_PKT = 1'b1
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_C1    = 2'd1,
        KIND_C2    = 2'd2,
        KIND_PLAIN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_TYPE = 2'd1,
        ERR_SIZE = 2'd2
    } frame_err_t;

endpackage

[hdl/typed_length_packet_deframer_top.sv]
// typed length packet deframer: header parsing, packet tracking and result register
//
// usage
//   s_valid/s_ready/s_in_byte carries the byte stream, one byte per transfer
//   m_valid/m_ready carries one result per input byte: the byte itself, packet
//   membership, offset in the packet, first/last flags, the command byte once
//   it has been seen, and an error code
//   cfg_wr_en/cfg_wr_data write framing_mode (0 typed C1/C2, 1 plain); write
//   it only while no transfer is in flight; it is sampled when hunting
// data path and throughput
//   a byte lands in the input register; when the result register is empty or
//   being taken, the header logic updates the packet state and fills the
//   result register from it
//   one byte per cycle sustained while m_ready stays high; the header/size state
//   is computed combinationally, so back-to-back bytes never wait on each other
// reset
//   aresetn (synchronous, active low) empties both registers, returns to
//   hunting and sets typed framing
// stall
//   while m_ready is low the result register holds; the input register still
//   takes one more byte, then s_ready drops until the result is taken
module typed_length_packet_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_in_packet,
    output logic [15:0] m_byte_offset,
    output logic        m_pkt_first,
    output logic        m_pkt_last,
    output logic [7:0]  m_head_code,
    output logic        m_head_valid,
    output logic [1:0]  m_frame_error
);

    // configuration
    logic framing_mode_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // packet state
    tlpd_pkg::phase_t phase_reg, phase_next;
    tlpd_pkg::kind_t  kind_reg, kind_next;
    logic [15:0]      size_reg, size_next;
    logic [15:0]      offset_reg, offset_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic             seen_reg, seen_next;

    // result register
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_in_packet_reg, out_in_packet_next;
    logic [15:0]          out_offset_reg;
    logic                 out_first_reg, out_first_next;
    logic                 out_last_reg;
    logic [7:0]           out_code_reg, out_code_next;
    logic                 out_head_valid_reg;
    tlpd_pkg::frame_err_t out_err_reg, out_err_next;

    // per-byte working values
    logic                 advance;
    logic                 hunting;
    logic                 bad_type;
    tlpd_pkg::kind_t      kind_cur;
    logic [15:0]          ofs;
    logic [15:0]          size_cur;
    logic [7:0]           cmd_cur;
    logic                 seen_cur;
    logic                 size_done;
    logic [15:0]          hdr_len;
    logic                 size_known;
    logic                 size_bad;
    logic                 last_byte;
    logic                 pkt_end;

    // the input register moves on when the result register is empty or being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            framing_mode_reg <= tlpd_pkg::MODE_TYPED;
        end else if (cfg_wr_en) begin
            framing_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // header parsing and packet tracking
    always_comb begin
        hunting  = (phase_reg == tlpd_pkg::PH_HUNT);
        bad_type = 1'b0;
        kind_cur = kind_reg;
        if (hunting) begin
            if (framing_mode_reg == tlpd_pkg::MODE_PLAIN) begin
                kind_cur = tlpd_pkg::KIND_PLAIN;
            end else if (in_byte_reg == tlpd_pkg::TYPE_C1) begin
                kind_cur = tlpd_pkg::KIND_C1;
            end else if (in_byte_reg == tlpd_pkg::TYPE_C2) begin
                kind_cur = tlpd_pkg::KIND_C2;
            end else begin
                kind_cur = tlpd_pkg::KIND_NONE;
                bad_type = 1'b1;
            end
        end

        // a new packet starts from cleared fields
        ofs      = hunting ? 16'd0 : offset_reg;
        size_cur = hunting ? 16'd0 : size_reg;
        cmd_cur  = hunting ? 8'd0 : cmd_reg;
        seen_cur = hunting ? 1'b0 : seen_reg;

        size_done = 1'b0;
        hdr_len   = tlpd_pkg::HDR_LEN_SHORT;
        unique case (kind_cur)
            tlpd_pkg::KIND_C1: begin
                if (ofs == 16'd1) begin
                    size_cur  = {8'd0, in_byte_reg};
                    size_done = 1'b1;
                end else if (ofs == 16'd2) begin
                    cmd_cur  = in_byte_reg;
                    seen_cur = 1'b1;
                end
            end
            tlpd_pkg::KIND_C2: begin
                hdr_len = tlpd_pkg::HDR_LEN_LONG;
                // big-endian size
                if (ofs == 16'd1) begin
                    size_cur = {in_byte_reg, 8'd0};
                end else if (ofs == 16'd2) begin
                    size_cur  = {size_cur[15:8], in_byte_reg};
                    size_done = 1'b1;
                end else if (ofs == 16'd3) begin
                    cmd_cur  = in_byte_reg;
                    seen_cur = 1'b1;
                end
            end
            tlpd_pkg::KIND_PLAIN: begin
                // command first, then little-endian size
                if (ofs == 16'd0) begin
                    cmd_cur  = in_byte_reg;
                    seen_cur = 1'b1;
                end else if (ofs == 16'd1) begin
                    size_cur = {8'd0, in_byte_reg};
                end else if (ofs == 16'd2) begin
                    size_cur  = {in_byte_reg, size_cur[7:0]};
                    size_done = 1'b1;
                end
            end
            default: begin
            end
        endcase

        size_bad   = size_done && (size_cur < hdr_len);
        size_known = ((kind_cur == tlpd_pkg::KIND_C1) && (ofs >= 16'd1)) || (ofs >= 16'd2);
        last_byte  = !size_bad && size_known &&
                     (({1'b0, ofs} + 17'd1) == {1'b0, size_cur});
        pkt_end    = size_bad || last_byte;

        // next packet state
        if (bad_type) begin
            phase_next  = tlpd_pkg::PH_HUNT;
            kind_next   = tlpd_pkg::KIND_NONE;
            size_next   = 16'd0;
            offset_next = 16'd0;
            cmd_next    = 8'd0;
            seen_next   = 1'b0;
        end else if (pkt_end) begin
            phase_next  = tlpd_pkg::PH_HUNT;
            kind_next   = tlpd_pkg::KIND_NONE;
            size_next   = 16'd0;
            offset_next = 16'd0;
            cmd_next    = 8'd0;
            seen_next   = 1'b0;
        end else begin
            phase_next  = tlpd_pkg::PH_IN_PKT;
            kind_next   = kind_cur;
            size_next   = size_cur;
            offset_next = ofs + 16'd1;
            cmd_next    = cmd_cur;
            seen_next   = seen_cur;
        end

        // result fields
        out_in_packet_next = !bad_type;
        out_first_next     = hunting && !bad_type;
        out_code_next      = seen_cur ? cmd_cur : 8'd0;
        if (bad_type) begin
            out_err_next = tlpd_pkg::ERR_TYPE;
        end else if (size_bad) begin
            out_err_next = tlpd_pkg::ERR_SIZE;
        end else begin
            out_err_next = tlpd_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= tlpd_pkg::PH_HUNT;
            kind_reg   <= tlpd_pkg::KIND_NONE;
            size_reg   <= 16'd0;
            offset_reg <= 16'd0;
            cmd_reg    <= 8'd0;
            seen_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            size_reg   <= size_next;
            offset_reg <= offset_next;
            cmd_reg    <= cmd_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload: a bad type byte reports zeros everywhere but byte and error
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg       <= in_byte_reg;
            out_in_packet_reg  <= out_in_packet_next;
            out_offset_reg     <= bad_type ? 16'd0 : ofs;
            out_first_reg      <= out_first_next;
            out_last_reg       <= last_byte && !bad_type;
            out_code_reg       <= bad_type ? 8'd0 : out_code_next;
            out_head_valid_reg <= seen_cur && !bad_type;
            out_err_reg        <= out_err_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_in_packet   = out_in_packet_reg;
    assign m_byte_offset = out_offset_reg;
    assign m_pkt_first   = out_first_reg;
    assign m_pkt_last    = out_last_reg;
    assign m_head_code   = out_code_reg;
    assign m_head_valid  = out_head_valid_reg;
    assign m_frame_error = out_err_reg;

    // a byte that neither errors nor ends its packet leaves the block inside a packet
    a_stay_in_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !bad_type && !pkt_end |=> phase_reg == tlpd_pkg::PH_IN_PKT)
        else $error("packet state lost after a mid-packet byte");

    // hunting always starts from a cleared packet context
    a_hunt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == tlpd_pkg::PH_HUNT |-> offset_reg == 16'd0 && !seen_reg)
        else $error("stale packet context while hunting");

    // a dropped type byte is never reported as packet data
    a_type_err_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_error == tlpd_pkg::ERR_TYPE |-> !m_in_packet && !m_pkt_first)
        else $error("type error reported inside a packet");

    // a packet's first byte sits at offset zero
    a_first_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pkt_first |-> m_byte_offset == 16'd0)
        else $error("first byte with nonzero offset");

    // a size error never coincides with a last byte and is reported inside a packet
    a_size_err_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_error == tlpd_pkg::ERR_SIZE |-> !m_pkt_last && m_in_packet)
        else $error("size error flagged as packet end");

endmodule
